// ===== rtl/mrac_pkg.sv =====
// ----------------------------------------------------------------------------
// mrac_pkg
// Types, codes and helpers shared by the mixed-radix add/convert block.
// ----------------------------------------------------------------------------
package mrac_pkg;

  // Field widths and storage sizes
  localparam int DIGIT_W   = 6;
  localparam int BASE_W    = 6;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int BUF_DEPTH = 32;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);

  typedef logic [DIGIT_W-1:0]   digit_t;
  typedef logic [BASE_W-1:0]    base_t;
  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [BUF_AW-1:0]    buf_addr_t;

  // Commands
  localparam cmd_t CMD_DIGIT_A = 2'd0;
  localparam cmd_t CMD_DIGIT_B = 2'd1;
  localparam cmd_t CMD_FINISH  = 2'd2;

  // Status codes
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_OVERFLOW  = 2'd1;
  localparam status_t STATUS_BAD_DIGIT = 2'd2;

  // Configuration register indexes
  localparam cfg_idx_t REG_BASE_A      = 2'd0;
  localparam cfg_idx_t REG_BASE_B      = 2'd1;
  localparam cfg_idx_t REG_BASE_RESULT = 2'd2;

  // Radix limits
  localparam base_t BASE_MIN   = 6'd2;
  localparam base_t BASE_MAX   = 6'd36;
  localparam base_t BASE_RESET = 6'd10;

  // Channel payloads
  typedef struct packed {
    cmd_t   command;
    digit_t digit_value;
  } in_item_t;

  typedef struct packed {
    digit_t  result_digit;
    logic    last_digit;
    status_t status;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_RD,
    S_OUT
  } state_t;

  // Divider request and response
  typedef struct packed {
    logic  start;
    base_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    digit_t remainder;
  } div_rsp_t;

  // Digit buffer write port
  typedef struct packed {
    logic      en;
    buf_addr_t addr;
    digit_t    data;
  } buf_wr_t;

  // Clamp a programmed radix into the legal range
  function automatic base_t eff_base(base_t r);
    base_t b;
    b = r;
    if (r < BASE_MIN) begin
      b = BASE_MIN;
    end else if (r > BASE_MAX) begin
      b = BASE_MAX;
    end
    return b;
  endfunction

endpackage

// ===== rtl/mrac_stream_if.sv =====
// ----------------------------------------------------------------------------
// mrac_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface mrac_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/mrac_divider.sv =====
// ----------------------------------------------------------------------------
// mrac_divider
// Restoring divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module mrac_divider #(
  parameter int ACC_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mrac_pkg::div_req_t    req,
  input  logic [ACC_WIDTH-1:0]  dividend,
  output mrac_pkg::div_rsp_t    rsp,
  output logic [ACC_WIDTH-1:0]  quotient
);
  import mrac_pkg::*;

  localparam int CNT_W = $clog2(ACC_WIDTH);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ACC_WIDTH-1:0] quo_r, quo_nxt;
  digit_t               rem_r, rem_nxt;
  base_t                dvs_r, dvs_nxt;
  logic [DIGIT_W:0]     trial;
  logic                 take;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[ACC_WIDTH-1]};
    take  = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ACC_WIDTH - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[ACC_WIDTH-2:0], take};
      if (take) begin
        rem_nxt = DIGIT_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[DIGIT_W-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;
  assign quotient      = quo_r;

endmodule

// ===== rtl/mrac_digit_buf.sv =====
// ----------------------------------------------------------------------------
// mrac_digit_buf
// Digit reversal memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mrac_digit_buf (
  input  logic                clk,
  input  mrac_pkg::buf_wr_t   wr,
  input  logic                rd_en,
  input  mrac_pkg::buf_addr_t rd_addr,
  output mrac_pkg::digit_t    rd_data
);
  import mrac_pkg::*;

  digit_t mem [BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/mixed_radix_add_convert.sv =====
// ----------------------------------------------------------------------------
// mixed_radix_add_convert
// Accumulates two mixed-radix operands and emits their sum in a result radix.
// ----------------------------------------------------------------------------
// Digit items (command 0 or 1) are folded as acc*base+digit and can be
// accepted back to back while idle; command 3 is dropped. A finish item
// converts the sum with a single restoring divider that produces one
// quotient bit per cycle; each result digit goes into the reversal memory,
// then the digits are read back in reverse order and presented. A finish
// producing n digits (1 to 32) keeps in_item.ready low until its last digit
// is taken, output stalls included; afterwards both accumulators and flags
// are clear. The three radix registers are clamped to 2..36 where used.
// ----------------------------------------------------------------------------
module mixed_radix_add_convert #(
  parameter int ACC_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mrac_stream_if.sink          in_item,
  mrac_stream_if.source        out_item,
  input  logic                 cfg_wr_en,
  input  mrac_pkg::cfg_idx_t   cfg_index,
  input  mrac_pkg::base_t      cfg_data
);
  import mrac_pkg::*;

  localparam int PROD_W = ACC_WIDTH + BASE_W;
  localparam int FOLD_W = PROD_W + 1;

  state_t               state_r, state_nxt;
  base_t                base_a_r, base_b_r, base_res_r;
  logic [ACC_WIDTH-1:0] acc_a_r, acc_a_nxt;
  logic [ACC_WIDTH-1:0] acc_b_r, acc_b_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 bad_r, bad_nxt;
  logic [ACC_WIDTH-1:0] sum_r, sum_nxt;
  buf_addr_t            n_r, n_nxt;
  buf_addr_t            rd_idx_r, rd_idx_nxt;

  logic                 in_fire, out_fire;
  cmd_t                 cmd;
  digit_t               dig;
  base_t                fold_base;
  logic [ACC_WIDTH-1:0] fold_acc;
  logic [PROD_W-1:0]    fold_prod;
  logic [FOLD_W-1:0]    fold_full;
  logic                 fold_ovf;
  logic [ACC_WIDTH:0]   fin_full;

  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic [ACC_WIDTH-1:0] div_quo;
  buf_wr_t              buf_wr;
  logic                 buf_rd_en;
  digit_t               buf_rd_data;
  status_t              status;

  assign cmd      = in_item.payload.command;
  assign dig      = in_item.payload.digit_value;
  assign in_fire  = in_item.valid && in_item.ready;
  assign out_fire = out_item.valid && out_item.ready;

  // Fold arithmetic: multiply-add with full-width overflow detect
  always_comb begin
    if (cmd == CMD_DIGIT_A) begin
      fold_base = eff_base(base_a_r);
      fold_acc  = acc_a_r;
    end else begin
      fold_base = eff_base(base_b_r);
      fold_acc  = acc_b_r;
    end
    fold_prod = PROD_W'(fold_acc) * PROD_W'(fold_base);
    fold_full = FOLD_W'(fold_prod) + FOLD_W'(dig);
    fold_ovf  = |fold_full[FOLD_W-1:ACC_WIDTH];
    fin_full  = {1'b0, acc_a_r} + {1'b0, acc_b_r};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && cmd == CMD_FINISH) begin
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (div_quo != '0 && n_r != buf_addr_t'(BUF_DEPTH - 1)) begin
            state_nxt = S_DIV_GO;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_fire) begin
          state_nxt = (rd_idx_r == '0) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_item.ready   = 1'b0;
    out_item.valid  = 1'b0;
    div_req.start   = 1'b0;
    div_req.divisor = eff_base(base_res_r);
    buf_wr.en       = 1'b0;
    buf_wr.addr     = n_r;
    buf_wr.data     = div_rsp.remainder;
    buf_rd_en       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_item.ready = 1'b1;
      end
      S_DIV_GO: begin
        div_req.start = 1'b1;
      end
      S_DIV_WAIT: begin
        buf_wr.en = div_rsp.done;
      end
      S_RD: begin
        buf_rd_en = 1'b1;
      end
      S_OUT: begin
        out_item.valid = 1'b1;
      end
      default: begin
        in_item.ready = 1'b0;
      end
    endcase
  end

  // Result payload
  always_comb begin
    if (bad_r) begin
      status = STATUS_BAD_DIGIT;
    end else if (ovf_r) begin
      status = STATUS_OVERFLOW;
    end else begin
      status = STATUS_OK;
    end
    out_item.payload.result_digit = buf_rd_data;
    out_item.payload.last_digit   = (rd_idx_r == '0);
    out_item.payload.status       = status;
  end

  // Accumulators, flags and conversion bookkeeping
  always_comb begin
    acc_a_nxt  = acc_a_r;
    acc_b_nxt  = acc_b_r;
    ovf_nxt    = ovf_r;
    bad_nxt    = bad_r;
    sum_nxt    = sum_r;
    n_nxt      = n_r;
    rd_idx_nxt = rd_idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (cmd == CMD_DIGIT_A || cmd == CMD_DIGIT_B) begin
            if (cmd == CMD_DIGIT_A) begin
              acc_a_nxt = fold_full[ACC_WIDTH-1:0];
            end else begin
              acc_b_nxt = fold_full[ACC_WIDTH-1:0];
            end
            if (fold_ovf) begin
              ovf_nxt = 1'b1;
            end
            if (dig >= fold_base) begin
              bad_nxt = 1'b1;
            end
          end else if (cmd == CMD_FINISH) begin
            sum_nxt = fin_full[ACC_WIDTH-1:0];
            n_nxt   = '0;
            if (fin_full[ACC_WIDTH]) begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end
      S_DIV_WAIT: begin
        // Store the remainder digit, advance to the quotient
        if (div_rsp.done) begin
          sum_nxt    = div_quo;
          n_nxt      = n_r + 1'b1;
          rd_idx_nxt = n_r;
          if (div_quo != '0 && n_r == buf_addr_t'(BUF_DEPTH - 1)) begin
            ovf_nxt = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (out_fire) begin
          if (rd_idx_r == '0) begin
            acc_a_nxt = '0;
            acc_b_nxt = '0;
            ovf_nxt   = 1'b0;
            bad_nxt   = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r - 1'b1;
          end
        end
      end
      default: begin
        sum_nxt = sum_r;
      end
    endcase
  end

  // Control state, accumulators, flags and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      base_a_r   <= BASE_RESET;
      base_b_r   <= BASE_RESET;
      base_res_r <= BASE_RESET;
      acc_a_r    <= '0;
      acc_b_r    <= '0;
      ovf_r      <= 1'b0;
      bad_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_a_r <= acc_a_nxt;
      acc_b_r <= acc_b_nxt;
      ovf_r   <= ovf_nxt;
      bad_r   <= bad_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BASE_A:      base_a_r   <= cfg_data;
          REG_BASE_B:      base_b_r   <= cfg_data;
          REG_BASE_RESULT: base_res_r <= cfg_data;
          default:         base_a_r   <= base_a_r;
        endcase
      end
    end
  end

  // Conversion payload registers
  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    n_r      <= n_nxt;
    rd_idx_r <= rd_idx_nxt;
  end

  mrac_divider #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (sum_r),
    .rsp      (div_rsp),
    .quotient (div_quo)
  );

  mrac_digit_buf u_buf (
    .clk     (clk),
    .wr      (buf_wr),
    .rd_en   (buf_rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (buf_rd_data)
  );

endmodule
